// File: hw/rtl/ced_pkg.sv
`default_nettype none

package ced_pkg;

	// Character codes
	localparam logic [7:0] CH_NL   = 8'h0A;
	localparam logic [7:0] CH_DQ   = 8'h22;
	localparam logic [7:0] CH_SQ   = 8'h27;
	localparam logic [7:0] CH_0    = 8'h30;
	localparam logic [7:0] CH_7    = 8'h37;
	localparam logic [7:0] CH_9    = 8'h39;
	localparam logic [7:0] CH_QM   = 8'h3F;
	localparam logic [7:0] CH_UA   = 8'h41;
	localparam logic [7:0] CH_UF   = 8'h46;
	localparam logic [7:0] CH_BSL  = 8'h5C;
	localparam logic [7:0] CH_A    = 8'h61;
	localparam logic [7:0] CH_B    = 8'h62;
	localparam logic [7:0] CH_F    = 8'h66;
	localparam logic [7:0] CH_N    = 8'h6E;
	localparam logic [7:0] CH_R    = 8'h72;
	localparam logic [7:0] CH_T    = 8'h74;
	localparam logic [7:0] CH_V    = 8'h76;
	localparam logic [7:0] CH_X    = 8'h78;

	// Control codes produced by simple escapes
	localparam logic [7:0] CC_BEL  = 8'h07;
	localparam logic [7:0] CC_BS   = 8'h08;
	localparam logic [7:0] CC_HT   = 8'h09;
	localparam logic [7:0] CC_LF   = 8'h0A;
	localparam logic [7:0] CC_VT   = 8'h0B;
	localparam logic [7:0] CC_FF   = 8'h0C;
	localparam logic [7:0] CC_CR   = 8'h0D;

	// Fault codes
	localparam logic [2:0] FAULT_OK        = 3'd0;
	localparam logic [2:0] FAULT_HEX_OVER  = 3'd1;
	localparam logic [2:0] FAULT_HEX_EMPTY = 3'd2;
	localparam logic [2:0] FAULT_OCT_OVER  = 3'd3;
	localparam logic [2:0] FAULT_UNKNOWN   = 3'd4;
	localparam logic [2:0] FAULT_TRAIL_BSL = 3'd5;

	// Result queue between front and back
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	typedef enum logic [4:0] {
		MODE_NORMAL = 5'b00001,
		MODE_ESC    = 5'b00010,
		MODE_HEX    = 5'b00100,
		MODE_OCT    = 5'b01000,
		MODE_DRAIN  = 5'b10000
	} mode_t;

	typedef struct packed {
		logic [7:0] data;
		logic       present;
		logic [2:0] fault;
		logic       done;
	} rslt_t;

	// One queue entry holds the results of one input byte (one or two)
	typedef struct packed {
		rslt_t r0;
		rslt_t r1;
		logic  two;
	} entry_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hexd_t;

	localparam rslt_t RSLT_NONE = '{data: 8'h00, present: 1'b0, fault: FAULT_OK, done: 1'b0};

	function automatic hexd_t hex_val(input logic [7:0] b);
		hexd_t h;
		logic [7:0] diff;
		h = '{ok: 1'b0, val: 4'h0};
		diff = 8'h00;
		if (b >= CH_0 && b <= CH_9) begin
			diff = b - CH_0;
			h = '{ok: 1'b1, val: diff[3:0]};
		end else if (b >= CH_A && b <= CH_F) begin
			diff = b - CH_A + 8'd10;
			h = '{ok: 1'b1, val: diff[3:0]};
		end else if (b >= CH_UA && b <= CH_UF) begin
			diff = b - CH_UA + 8'd10;
			h = '{ok: 1'b1, val: diff[3:0]};
		end
		return h;
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/ced_front.sv
`default_nettype none

module ced_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            accept,
	input  wire logic [7:0]      body_byte,
	input  wire logic            body_end,
	output ced_pkg::entry_t      push_data,
	output logic                 push
);

	ced_pkg::mode_t   mode_q, mode_d;
	logic [8:0]       val_q, val_d;
	logic [1:0]       cnt_q, cnt_d;

	ced_pkg::rslt_t   res [2];
	logic [1:0]       n;
	logic [1:0]       n_m1;
	logic             used;
	logic             stop;
	logic             drain;
	logic [2:0]       fault;
	ced_pkg::hexd_t   hv;
	logic             is_oct;
	logic [12:0]      hsum;
	logic [11:0]      osum;

	assign hv     = ced_pkg::hex_val(body_byte);
	assign is_oct = (body_byte >= ced_pkg::CH_0) && (body_byte <= ced_pkg::CH_7);
	assign hsum   = {val_q, 4'h0} + {9'h000, hv.val};
	assign osum   = {val_q, 3'b000} + {9'h000, body_byte[2:0]};

	// Classify the byte and work out the next escape state and its results
	always_comb begin
		mode_d = mode_q;
		val_d  = val_q;
		cnt_d  = cnt_q;
		res[0] = ced_pkg::RSLT_NONE;
		res[1] = ced_pkg::RSLT_NONE;
		n      = 2'd0;
		n_m1   = 2'd0;
		used   = 1'b0;
		stop   = 1'b0;
		drain  = 1'b0;
		fault  = ced_pkg::FAULT_OK;

		// Continue or close a pending numeric escape, or drain a faulted run
		case (mode_q)
			ced_pkg::MODE_DRAIN: begin
				drain = 1'b1;
				stop  = 1'b1;
				if (body_end) begin
					mode_d = ced_pkg::MODE_NORMAL;
					val_d  = 9'd0;
					cnt_d  = 2'd0;
				end
			end
			ced_pkg::MODE_HEX: begin
				if (hv.ok) begin
					if (hsum[12:8] != 5'd0) begin
						fault = ced_pkg::FAULT_HEX_OVER;
						stop  = 1'b1;
					end else begin
						val_d = hsum[8:0];
						if (cnt_q != 2'd3) begin
							cnt_d = cnt_q + 2'd1;
						end
						used = 1'b1;
					end
				end else if (cnt_q == 2'd0) begin
					fault = ced_pkg::FAULT_HEX_EMPTY;
					stop  = 1'b1;
				end else begin
					res[n[0]] = '{data: val_q[7:0], present: 1'b1,
						fault: ced_pkg::FAULT_OK, done: 1'b0};
					n      = n + 2'd1;
					mode_d = ced_pkg::MODE_NORMAL;
					val_d  = 9'd0;
					cnt_d  = 2'd0;
				end
			end
			ced_pkg::MODE_OCT: begin
				if (is_oct) begin
					used = 1'b1;
					if (cnt_q >= 2'd2) begin
						if (osum[11:8] != 4'd0) begin
							fault = ced_pkg::FAULT_OCT_OVER;
							stop  = 1'b1;
						end else begin
							res[n[0]] = '{data: osum[7:0], present: 1'b1,
								fault: ced_pkg::FAULT_OK, done: 1'b0};
							n      = n + 2'd1;
							mode_d = ced_pkg::MODE_NORMAL;
							val_d  = 9'd0;
							cnt_d  = 2'd0;
						end
					end else begin
						val_d = osum[8:0];
						cnt_d = cnt_q + 2'd1;
					end
				end else begin
					res[n[0]] = '{data: val_q[7:0], present: 1'b1,
						fault: ced_pkg::FAULT_OK, done: 1'b0};
					n      = n + 2'd1;
					mode_d = ced_pkg::MODE_NORMAL;
					val_d  = 9'd0;
					cnt_d  = 2'd0;
				end
			end
			default: begin
			end
		endcase

		// Handle the byte itself: after a backslash, or as plain text
		if (!stop && !used) begin
			if (mode_d == ced_pkg::MODE_ESC) begin
				mode_d = ced_pkg::MODE_NORMAL;
				case (body_byte)
					ced_pkg::CH_NL: begin
					end
					ced_pkg::CH_A, ced_pkg::CH_B, ced_pkg::CH_F, ced_pkg::CH_N,
					ced_pkg::CH_R, ced_pkg::CH_T, ced_pkg::CH_V,
					ced_pkg::CH_BSL, ced_pkg::CH_SQ, ced_pkg::CH_DQ, ced_pkg::CH_QM: begin
						res[n[0]] = '{data: body_byte, present: 1'b1,
							fault: ced_pkg::FAULT_OK, done: 1'b0};
						case (body_byte)
							ced_pkg::CH_A: res[n[0]].data = ced_pkg::CC_BEL;
							ced_pkg::CH_B: res[n[0]].data = ced_pkg::CC_BS;
							ced_pkg::CH_F: res[n[0]].data = ced_pkg::CC_FF;
							ced_pkg::CH_N: res[n[0]].data = ced_pkg::CC_LF;
							ced_pkg::CH_R: res[n[0]].data = ced_pkg::CC_CR;
							ced_pkg::CH_T: res[n[0]].data = ced_pkg::CC_HT;
							ced_pkg::CH_V: res[n[0]].data = ced_pkg::CC_VT;
							default: begin
							end
						endcase
						n = n + 2'd1;
					end
					ced_pkg::CH_X: begin
						mode_d = ced_pkg::MODE_HEX;
						val_d  = 9'd0;
						cnt_d  = 2'd0;
					end
					default: begin
						if (is_oct) begin
							mode_d = ced_pkg::MODE_OCT;
							val_d  = {6'd0, body_byte[2:0]};
							cnt_d  = 2'd1;
						end else begin
							fault = ced_pkg::FAULT_UNKNOWN;
							stop  = 1'b1;
						end
					end
				endcase
			end else begin
				mode_d = ced_pkg::MODE_NORMAL;
				if (body_byte == ced_pkg::CH_BSL) begin
					mode_d = ced_pkg::MODE_ESC;
				end else begin
					res[n[0]] = '{data: body_byte, present: 1'b1,
						fault: ced_pkg::FAULT_OK, done: 1'b0};
					n = n + 2'd1;
				end
			end
		end

		// Close the run on the final byte
		if (!stop && body_end) begin
			if (mode_d == ced_pkg::MODE_ESC) begin
				fault = ced_pkg::FAULT_TRAIL_BSL;
			end else if (mode_d == ced_pkg::MODE_HEX && cnt_d == 2'd0) begin
				fault = ced_pkg::FAULT_HEX_EMPTY;
			end else if (mode_d == ced_pkg::MODE_HEX || mode_d == ced_pkg::MODE_OCT) begin
				res[n[0]] = '{data: val_d[7:0], present: 1'b1,
					fault: ced_pkg::FAULT_OK, done: 1'b0};
				n = n + 2'd1;
			end
			mode_d = ced_pkg::MODE_NORMAL;
			val_d  = 9'd0;
			cnt_d  = 2'd0;
		end

		// Append a fault result and leave the run
		if (fault != ced_pkg::FAULT_OK) begin
			res[n[0]] = '{data: 8'h00, present: 1'b0, fault: fault, done: 1'b1};
			n      = n + 2'd1;
			mode_d = body_end ? ced_pkg::MODE_NORMAL : ced_pkg::MODE_DRAIN;
			val_d  = 9'd0;
			cnt_d  = 2'd0;
		end

		// Mark the last result of the run, or give an empty marker
		if (body_end && !drain) begin
			if (n == 2'd0) begin
				res[0] = '{data: 8'h00, present: 1'b0, fault: ced_pkg::FAULT_OK, done: 1'b1};
				n      = 2'd1;
			end else begin
				n_m1 = n - 2'd1;
				res[n_m1[0]].done = 1'b1;
			end
		end
	end

	assign push      = accept && (n != 2'd0);
	assign push_data = '{r0: res[0], r1: res[1], two: n[1]};

	// Advance the escape state on each accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= ced_pkg::MODE_NORMAL;
			val_q  <= 9'd0;
			cnt_q  <= 2'd0;
		end else if (accept) begin
			mode_q <= mode_d;
			val_q  <= val_d;
			cnt_q  <= cnt_d;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/ced_queue.sv
`default_nettype none

module ced_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire ced_pkg::entry_t push_data,
	output logic                 full,
	input  wire logic            pop,
	output ced_pkg::entry_t      head,
	output logic                 head_valid
);

	ced_pkg::entry_t          mem_q [ced_pkg::QDEPTH];
	logic [ced_pkg::QAW-1:0]  wr_ptr_q;
	logic [ced_pkg::QAW-1:0]  rd_ptr_q;
	logic [ced_pkg::QAW:0]    count_q;

	assign full       = (count_q == (ced_pkg::QAW+1)'(ced_pkg::QDEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + ced_pkg::QAW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + ced_pkg::QAW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (ced_pkg::QAW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (ced_pkg::QAW+1)'(1);
			end
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/ced_back.sv
`default_nettype none

module ced_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire ced_pkg::entry_t head,
	input  wire logic            head_valid,
	output logic                 pop,
	output logic                 out_valid,
	input  wire logic            out_stall,
	output ced_pkg::rslt_t       out_rslt
);

	logic            out_valid_q;
	ced_pkg::rslt_t  out_q;
	logic            sel_q;
	logic            load;
	logic            first_of_two;

	assign load         = !out_valid_q || !out_stall;
	assign first_of_two = head.two && !sel_q;
	assign pop          = load && head_valid && !first_of_two;

	// Load the output register with the next result of the head entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sel_q       <= 1'b0;
		end else if (load) begin
			out_valid_q <= head_valid;
			if (head_valid) begin
				sel_q <= first_of_two;
			end
		end
	end

	// Hold payload while stalled
	always_ff @(posedge clk) begin
		if (load && head_valid) begin
			out_q <= sel_q ? head.r1 : head.r0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_rslt  = out_q;

endmodule

`default_nettype wire

// File: hw/rtl/c_escape_sequence_decoder.sv
`default_nettype none

// Channel | Direction | Handshake              | Payload
// in      | input     | in_valid / in_stall    | body_byte[7:0], body_end
// out     | output    | out_valid / out_stall  | decoded_byte[7:0], byte_present,
//         |           |                        | fault_code[2:0], run_done
//
// One byte is accepted per cycle while in_stall is low; the escape state
// updates in the same cycle. A byte yields zero, one or two results;
// two-result bytes occupy the output register once per result, and a
// four-entry queue absorbs the difference.
// Reset clears the escape state, the queue and the output valid at once.
// in_stall rises only when the queue is full; out_stall holds the result.

module c_escape_sequence_decoder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  body_byte,
	input  wire logic        body_end,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       decoded_byte,
	output logic             byte_present,
	output logic [2:0]       fault_code,
	output logic             run_done
);

	logic             accept;
	logic             push;
	ced_pkg::entry_t  push_data;
	logic             full;
	logic             pop;
	ced_pkg::entry_t  head;
	logic             head_valid;
	ced_pkg::rslt_t   out_rslt;

	assign in_stall = full;
	assign accept   = in_valid && !full;

	ced_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.body_byte (body_byte),
		.body_end  (body_end),
		.push_data (push_data),
		.push      (push)
	);

	ced_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.full       (full),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid)
	);

	ced_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_rslt   (out_rslt)
	);

	assign decoded_byte = out_rslt.data;
	assign byte_present = out_rslt.present;
	assign fault_code   = out_rslt.fault;
	assign run_done     = out_rslt.done;

	// A fault always ends the run and carries no byte
	a_fault_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (fault_code != ced_pkg::FAULT_OK) |-> run_done && !byte_present)
		else $error("fault result without run end");

	// A result with neither byte nor fault is only the end-of-run marker
	a_empty_is_marker: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !byte_present && (fault_code == ced_pkg::FAULT_OK) |-> run_done)
		else $error("empty result that does not end the run");

	// A full queue implies the back side is offering a result
	a_full_offers: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled while output idle");

	// The queue never pops when empty
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from empty queue");

endmodule

`default_nettype wire

// File: tb/c_escape_sequence_decoder_tb.sv
`timescale 1ns / 1ps

module c_escape_sequence_decoder_tb;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int RANDOM_ITEMS  = 1020;
	localparam int N_DIRECTED    = 30;
	localparam int FROM_MODEL    = -1;
	localparam int QUIET_FIRST   = 300;
	localparam int QUIET_LAST    = 550;
	localparam int DRAIN_CYCLES  = 8;

	typedef struct packed {
		logic [7:0] b;
		logic       e;
	} body_item_t;

	// One directed transaction; n (zero or one) results typed in, or FROM_MODEL
	typedef struct {
		logic [7:0]      b;
		logic            e;
		int              n;
		ced_pkg::rslt_t  r;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  body_byte = 8'h00;
	logic        body_end = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  decoded_byte;
	logic        byte_present;
	logic [2:0]  fault_code;
	logic        run_done;

	// Decoder state mirrored by the predictor
	ced_pkg::mode_t  esc_mode;
	logic [8:0]      esc_value;
	logic [1:0]      esc_digits;

	ced_pkg::rslt_t  step_results[$];
	ced_pkg::rslt_t  pending_decodes[$];
	dir_row_t        directed_rows [N_DIRECTED];
	int              err_count = 0;
	int              cycles = 0;
	logic            quiet = 1'b0;

	c_escape_sequence_decoder DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.body_byte    (body_byte),
		.body_end     (body_end),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.decoded_byte (decoded_byte),
		.byte_present (byte_present),
		.fault_code   (fault_code),
		.run_done     (run_done)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string what);
		$display("ERROR @%0t: %s", $realtime, what);
		err_count++;
	endtask

	function automatic void clear_escape();
		esc_mode = ced_pkg::MODE_NORMAL;
		esc_value = '0;
		esc_digits = '0;
	endfunction

	function automatic void emit_byte(input logic [7:0] data);
		step_results.push_back('{data: data, present: 1'b1, fault: ced_pkg::FAULT_OK,
			done: 1'b0});
	endfunction

	// Fault ends the run: drain the rest unless this byte already ends it
	function automatic void emit_fault(input logic [2:0] code, input logic e);
		step_results.push_back('{data: 8'h00, present: 1'b0, fault: code, done: 1'b1});
		clear_escape();
		if (!e) begin
			esc_mode = ced_pkg::MODE_DRAIN;
		end
	endfunction

	function automatic int hex_digit(input logic [7:0] b);
		if (b >= ced_pkg::CH_0 && b <= ced_pkg::CH_9) return int'(b - ced_pkg::CH_0);
		if (b >= ced_pkg::CH_A && b <= ced_pkg::CH_F) return int'(b - ced_pkg::CH_A) + 10;
		if (b >= ced_pkg::CH_UA && b <= ced_pkg::CH_UF) return int'(b - ced_pkg::CH_UA) + 10;
		return -1;
	endfunction

	// Advance the escape state by one body byte; results land in step_results
	function automatic void decode_step(input logic [7:0] b, input logic e);
		int   d;
		int   v;
		logic used;
		logic [7:0] c;
		logic out_byte;
		step_results.delete();
		used = 1'b0;
		if (esc_mode == ced_pkg::MODE_DRAIN) begin
			if (e) clear_escape();
			return;
		end
		if (esc_mode == ced_pkg::MODE_HEX) begin
			d = hex_digit(b);
			if (d >= 0) begin
				v = int'(esc_value) * 16 + d;
				if (v > 255) begin
					emit_fault(ced_pkg::FAULT_HEX_OVER, e);
					return;
				end
				esc_value = v[8:0];
				if (esc_digits < 2'd3) esc_digits++;
				used = 1'b1;
			end else begin
				if (esc_digits == 2'd0) begin
					emit_fault(ced_pkg::FAULT_HEX_EMPTY, e);
					return;
				end
				emit_byte(esc_value[7:0]);
				clear_escape();
			end
		end else if (esc_mode == ced_pkg::MODE_OCT) begin
			if (b >= ced_pkg::CH_0 && b <= ced_pkg::CH_7) begin
				v = int'(esc_value) * 8 + int'(b - ced_pkg::CH_0);
				esc_digits++;
				used = 1'b1;
				if (esc_digits == 2'd3) begin
					if (v > 255) begin
						emit_fault(ced_pkg::FAULT_OCT_OVER, e);
						return;
					end
					emit_byte(v[7:0]);
					clear_escape();
				end else begin
					esc_value = v[8:0];
				end
			end else begin
				emit_byte(esc_value[7:0]);
				clear_escape();
			end
		end
		if (!used) begin
			if (esc_mode == ced_pkg::MODE_ESC) begin
				c = b;
				out_byte = 1'b1;
				esc_mode = ced_pkg::MODE_NORMAL;
				case (b)
					ced_pkg::CH_NL: out_byte = 1'b0;
					ced_pkg::CH_A: c = ced_pkg::CC_BEL;
					ced_pkg::CH_B: c = ced_pkg::CC_BS;
					ced_pkg::CH_F: c = ced_pkg::CC_FF;
					ced_pkg::CH_N: c = ced_pkg::CC_LF;
					ced_pkg::CH_R: c = ced_pkg::CC_CR;
					ced_pkg::CH_T: c = ced_pkg::CC_HT;
					ced_pkg::CH_V: c = ced_pkg::CC_VT;
					ced_pkg::CH_BSL, ced_pkg::CH_SQ, ced_pkg::CH_DQ, ced_pkg::CH_QM: ;
					ced_pkg::CH_X: begin
						esc_mode = ced_pkg::MODE_HEX;
						esc_value = '0;
						esc_digits = '0;
						out_byte = 1'b0;
					end
					default: begin
						if (b >= ced_pkg::CH_0 && b <= ced_pkg::CH_7) begin
							esc_mode = ced_pkg::MODE_OCT;
							esc_value = {1'b0, b - ced_pkg::CH_0};
							esc_digits = 2'd1;
							out_byte = 1'b0;
						end else begin
							emit_fault(ced_pkg::FAULT_UNKNOWN, e);
							return;
						end
					end
				endcase
				if (out_byte) emit_byte(c);
			end else begin
				esc_mode = ced_pkg::MODE_NORMAL;
				if (b == ced_pkg::CH_BSL) esc_mode = ced_pkg::MODE_ESC;
				else emit_byte(b);
			end
		end
		// Close the body: flush open escapes, mark the last result
		if (e) begin
			if (esc_mode == ced_pkg::MODE_ESC) begin
				emit_fault(ced_pkg::FAULT_TRAIL_BSL, 1'b1);
				return;
			end
			if (esc_mode == ced_pkg::MODE_HEX) begin
				if (esc_digits == 2'd0) begin
					emit_fault(ced_pkg::FAULT_HEX_EMPTY, 1'b1);
					return;
				end
				emit_byte(esc_value[7:0]);
			end else if (esc_mode == ced_pkg::MODE_OCT) begin
				emit_byte(esc_value[7:0]);
			end
			clear_escape();
			if (step_results.size() == 0) begin
				step_results.push_back('{data: 8'h00, present: 1'b0,
					fault: ced_pkg::FAULT_OK, done: 1'b1});
			end
			step_results[step_results.size() - 1].done = 1'b1;
		end
	endfunction

	// Drive one transaction, hold it through stalls, then record expectations
	task automatic send_item(input logic [7:0] b, input logic e, input int n,
			input ced_pkg::rslt_t r);
		while (!quiet && $urandom_range(0, 99) < 6) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		body_byte <= b;
		body_end <= e;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		decode_step(b, e);
		if (n == FROM_MODEL) begin
			foreach (step_results[i]) pending_decodes.push_back(step_results[i]);
		end else if (n == 1) begin
			pending_decodes.push_back(r);
		end
	endtask

	function automatic logic [7:0] pick_hex_char();
		int r;
		r = $urandom_range(0, 21);
		if (r < 10) return ced_pkg::CH_0 + 8'(r);
		if (r < 16) return ced_pkg::CH_A + 8'(r - 10);
		return ced_pkg::CH_UA + 8'(r - 16);
	endfunction

	// Build one literal body: mostly well-formed escapes, some noise
	task automatic build_literal(ref body_item_t lit[$]);
		logic [7:0] simple_esc [12];
		int tokens;
		int kind;
		int k;
		simple_esc = '{ced_pkg::CH_A, ced_pkg::CH_B, ced_pkg::CH_F, ced_pkg::CH_N,
			ced_pkg::CH_R, ced_pkg::CH_T, ced_pkg::CH_V, ced_pkg::CH_BSL, ced_pkg::CH_SQ,
			ced_pkg::CH_DQ, ced_pkg::CH_QM, ced_pkg::CH_NL};
		lit.delete();
		tokens = $urandom_range(1, 10);
		for (int t = 0; t < tokens; t++) begin
			kind = $urandom_range(0, 99);
			if (kind < 40) begin
				lit.push_back('{b: 8'($urandom_range(0, 255)), e: 1'b0});
			end else if (kind < 58) begin
				lit.push_back('{b: ced_pkg::CH_BSL, e: 1'b0});
				lit.push_back('{b: simple_esc[$urandom_range(0, 11)], e: 1'b0});
			end else if (kind < 76) begin
				lit.push_back('{b: ced_pkg::CH_BSL, e: 1'b0});
				lit.push_back('{b: ced_pkg::CH_X, e: 1'b0});
				k = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4) : $urandom_range(1, 2);
				repeat (k) lit.push_back('{b: pick_hex_char(), e: 1'b0});
			end else if (kind < 94) begin
				lit.push_back('{b: ced_pkg::CH_BSL, e: 1'b0});
				k = $urandom_range(1, 3);
				repeat (k) lit.push_back('{b: ced_pkg::CH_0 + 8'($urandom_range(0, 7)),
					e: 1'b0});
			end else begin
				lit.push_back('{b: ced_pkg::CH_BSL, e: 1'b0});
				lit.push_back('{b: 8'($urandom_range(0, 255)), e: 1'b0});
			end
		end
		if ($urandom_range(0, 19) == 0) lit.push_back('{b: ced_pkg::CH_BSL, e: 1'b0});
		lit[lit.size() - 1].e = 1'b1;
	endtask

	// Check each delivered result against the oldest expectation
	always @(posedge clk) begin
		ced_pkg::rslt_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_decodes.size() == 0) begin
				report_mismatch($sformatf(
					"unexpected result byte=%02h present=%0b fault=%0d done=%0b",
					decoded_byte, byte_present, fault_code, run_done));
			end else begin
				exp_r = pending_decodes.pop_front();
				if (decoded_byte !== exp_r.data)
					report_mismatch($sformatf("decoded_byte %02h, want %02h", decoded_byte,
						exp_r.data));
				if (byte_present !== exp_r.present)
					report_mismatch($sformatf("byte_present %0b, want %0b", byte_present,
						exp_r.present));
				if (fault_code !== exp_r.fault)
					report_mismatch($sformatf("fault_code %0d, want %0d", fault_code,
						exp_r.fault));
				if (run_done !== exp_r.done)
					report_mismatch($sformatf("run_done %0b, want %0b", run_done, exp_r.done));
			end
		end
		out_stall <= (!quiet && $urandom_range(0, 99) < 6);
	end

	// Bound the run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("c_escape_sequence_decoder: mismatch");
			$finish;
		end
	end

	initial begin
		body_item_t lit[$];
		int random_sent;
		directed_rows = '{
			'{8'h00, 1'b0, 1, '{8'h00, 1'b1, ced_pkg::FAULT_OK, 1'b0}},
			'{8'hFF, 1'b1, 1, '{8'hFF, 1'b1, ced_pkg::FAULT_OK, 1'b1}},
			'{ced_pkg::CH_BSL, 1'b0, 0, ced_pkg::RSLT_NONE},
			'{ced_pkg::CH_N, 1'b0, 1, '{ced_pkg::CC_LF, 1'b1, ced_pkg::FAULT_OK, 1'b0}},
			// hex value runs past a byte
			'{ced_pkg::CH_BSL, 1'b0, 0, ced_pkg::RSLT_NONE},
			'{ced_pkg::CH_X, 1'b0, 0, ced_pkg::RSLT_NONE},
			'{ced_pkg::CH_0 + 8'd1, 1'b0, 0, ced_pkg::RSLT_NONE},
			'{ced_pkg::CH_0, 1'b0, 0, ced_pkg::RSLT_NONE},
			'{ced_pkg::CH_0, 1'b0, 1, '{8'h00, 1'b0, ced_pkg::FAULT_HEX_OVER, 1'b1}},
			// drained byte with the end flag gives nothing
			'{8'h51, 1'b1, 0, ced_pkg::RSLT_NONE},
			'{ced_pkg::CH_BSL, 1'b1, 1, '{8'h00, 1'b0, ced_pkg::FAULT_TRAIL_BSL, 1'b1}},
			'{ced_pkg::CH_BSL, 1'b0, 0, ced_pkg::RSLT_NONE},
			'{ced_pkg::CH_X, 1'b0, 0, ced_pkg::RSLT_NONE},
			'{8'h7A, 1'b0, 1, '{8'h00, 1'b0, ced_pkg::FAULT_HEX_EMPTY, 1'b1}},
			'{8'h00, 1'b1, 0, ced_pkg::RSLT_NONE},
			// third octal digit overflows
			'{ced_pkg::CH_BSL, 1'b0, 0, ced_pkg::RSLT_NONE},
			'{ced_pkg::CH_0 + 8'd4, 1'b0, 0, ced_pkg::RSLT_NONE},
			'{ced_pkg::CH_0, 1'b0, 0, ced_pkg::RSLT_NONE},
			'{ced_pkg::CH_0, 1'b1, 1, '{8'h00, 1'b0, ced_pkg::FAULT_OCT_OVER, 1'b1}},
			'{ced_pkg::CH_BSL, 1'b0, 0, ced_pkg::RSLT_NONE},
			'{ced_pkg::CH_9 - 8'd1, 1'b1, 1,
				'{8'h00, 1'b0, ced_pkg::FAULT_UNKNOWN, 1'b1}},
			// octal open at the end flushes
			'{ced_pkg::CH_BSL, 1'b0, 0, ced_pkg::RSLT_NONE},
			'{ced_pkg::CH_7, 1'b1, 1, '{8'h07, 1'b1, ced_pkg::FAULT_OK, 1'b1}},
			'{ced_pkg::CH_BSL, 1'b0, 0, ced_pkg::RSLT_NONE},
			'{ced_pkg::CH_X, 1'b1, 1, '{8'h00, 1'b0, ced_pkg::FAULT_HEX_EMPTY, 1'b1}},
			// line continuation at the end leaves only the marker
			'{ced_pkg::CH_BSL, 1'b0, 0, ced_pkg::RSLT_NONE},
			'{ced_pkg::CH_NL, 1'b1, 1, '{8'h00, 1'b0, ced_pkg::FAULT_OK, 1'b1}},
			// terminating byte after octal yields two results
			'{ced_pkg::CH_BSL, 1'b0, FROM_MODEL, ced_pkg::RSLT_NONE},
			'{ced_pkg::CH_0 + 8'd3, 1'b0, FROM_MODEL, ced_pkg::RSLT_NONE},
			'{8'h67, 1'b1, FROM_MODEL, ced_pkg::RSLT_NONE}
		};
		clear_escape();

		// Hold reset, then release on an edge
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			send_item(directed_rows[i].b, directed_rows[i].e, directed_rows[i].n,
				directed_rows[i].r);
		end

		random_sent = 0;
		while (random_sent < RANDOM_ITEMS) begin
			build_literal(lit);
			foreach (lit[i]) begin
				quiet = (random_sent >= QUIET_FIRST && random_sent < QUIET_LAST);
				random_sent++;
				send_item(lit[i].b, lit[i].e, FROM_MODEL, ced_pkg::RSLT_NONE);
			end
		end
		in_valid <= 1'b0;
		quiet = 1'b0;

		// Wait out the outstanding results, then settle
		while (pending_decodes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0) begin
			$display("c_escape_sequence_decoder: match");
		end else begin
			$display("c_escape_sequence_decoder: mismatch");
		end
		$finish;
	end

endmodule
